FILE: sv/frt_pkg.sv
// Shared types and constants for the fragment range table.
// Holds the item structs, action codes, the table entry layout and the controller states.
// No dependencies.
`default_nettype none

package frt_pkg;

  // Default number of table slots.
  localparam int unsigned FRT_CAPACITY = 64;

  // Action codes carried in the action field of an input item.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_ADJUST = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic [30:0]        position;
    logic signed [31:0] amount;
    logic [5:0]         slot_index;
  } frt_in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] slot_out;
    logic       table_full;
    logic [6:0] active_count;
  } frt_out_t;

  // One table slot as stored in memory.
  typedef struct packed {
    logic        active;
    logic [31:0] start;
    logic [31:0] length;
  } frt_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_FINISH
  } frt_state_t;

endpackage

`default_nettype wire

FILE: sv/frt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Used for the range table storage. No dependencies.
`default_nettype none

module frt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/fragment_range_table.sv
// Fragment range table top level: controller, counters and the slot memory.
// Depends on frt_pkg and frt_ram.
`default_nettype none

// Usage
// Items arrive on the in_ channel (in_valid / in_stall / in_data) and each one
// produces exactly one result item on the out_ channel (out_valid / out_stall /
// out_data). An item is taken when valid is high and stall is low.
// Slots live in one memory with a registered read; a fill count marks which slots
// hold data, so nothing needs to be swept after reset or clear.
// Steps from the accepting edge until the result register is loaded:
//   add, clear and unknown actions: straight to the finish state.
//   remove: read the slot, then write back its cleared active mark.
//   find and adjust: a scan over the used slots, one slot per cycle through
//   the single memory read port; find stops at the first hit.
// The controller returns to idle as the result is loaded and then takes the
// next item, even if the previous result still sits in the output register;
// the input is stalled while an item is in progress.
// If the receiver stalls, a finished result waits in the controller until the
// output register frees, and the input stays stalled meanwhile.
// Reset (rst_n low, synchronous) empties the table and drops any pending result.

module fragment_range_table #(
  parameter int unsigned CAPACITY = frt_pkg::FRT_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire frt_pkg::frt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output frt_pkg::frt_out_t     out_data
);

  // Slot index width, count width and the width used to compare the remove index.
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 6) ? CW : 6;
  localparam int unsigned EW = $bits(frt_pkg::frt_entry_t);

  // Control state.
  frt_pkg::frt_state_t state_r, state_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload state.
  logic [2:0]          op_r, op_nxt;
  logic [30:0]         pos_r, pos_nxt;
  logic [31:0]         amt_r, amt_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [5:0]          slot_r, slot_nxt;
  logic                full_r, full_nxt;
  frt_pkg::frt_out_t   out_r, out_nxt;

  // Memory port signals.
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_raddr;
  frt_pkg::frt_entry_t ram_wentry;
  frt_pkg::frt_entry_t rd_entry;
  logic [EW-1:0]       ram_rdata;

  // Range tests on the slot read back during a scan.
  logic [31:0]         pos_ext;
  logic [31:0]         range_end;
  logic                at_or_after_start;
  logic                at_or_before_start;
  logic                before_end;
  logic                last_slot;
  logic [XW-1:0]       rem_idx;

  frt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wentry),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_entry = frt_pkg::frt_entry_t'(ram_rdata);

  // Starts and ends are compared as signed 32-bit values; the position is never negative.
  assign pos_ext            = {1'b0, pos_r};
  assign range_end          = rd_entry.start + rd_entry.length;
  assign at_or_after_start  = $signed(pos_ext) >= $signed(rd_entry.start);
  assign at_or_before_start = $signed(pos_ext) <= $signed(rd_entry.start);
  assign before_end         = $signed(pos_ext) < $signed(range_end);
  assign last_slot          = (CW'(idx_r) + CW'(1)) == used_r;
  assign rem_idx            = XW'(in_data.slot_index);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && out_stall;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    amt_nxt       = amt_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wentry    = rd_entry;
    ram_raddr     = idx_r + IW'(1);

    case (state_r)
      frt_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.action;
          pos_nxt   = in_data.position;
          amt_nxt   = in_data.amount;
          found_nxt = 1'b0;
          slot_nxt  = 6'd0;
          full_nxt  = 1'b0;
          state_nxt = frt_pkg::ST_FINISH;
          case (in_data.action)
            frt_pkg::ACT_ADD: begin
              if (used_r == CW'(CAPACITY)) begin
                full_nxt = 1'b1;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = used_r[IW-1:0];
                ram_wentry.active = 1'b1;
                ram_wentry.start  = {1'b0, in_data.position};
                ram_wentry.length = in_data.amount;
                slot_nxt          = 6'(used_r);
                used_nxt          = used_r + CW'(1);
                live_nxt          = live_r + CW'(1);
              end
            end
            frt_pkg::ACT_REMOVE: begin
              // Slots at or above the fill count are unused and the remove is ignored.
              if (rem_idx < XW'(used_r)) begin
                ram_raddr = rem_idx[IW-1:0];
                idx_nxt   = rem_idx[IW-1:0];
                state_nxt = frt_pkg::ST_RMW;
              end
            end
            frt_pkg::ACT_CLEAR: begin
              used_nxt = '0;
              live_nxt = '0;
            end
            frt_pkg::ACT_FIND, frt_pkg::ACT_ADJUST: begin
              if (used_r != '0) begin
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = frt_pkg::ST_SCAN;
              end
            end
            default: begin
              state_nxt = frt_pkg::ST_FINISH;
            end
          endcase
        end
      end

      frt_pkg::ST_RMW: begin
        if (rd_entry.active) begin
          ram_we            = 1'b1;
          ram_wentry.active = 1'b0;
          live_nxt          = live_r - CW'(1);
        end
        state_nxt = frt_pkg::ST_FINISH;
      end

      frt_pkg::ST_SCAN: begin
        // The slot at idx_r is on the read port; the next one is being fetched.
        idx_nxt = idx_r + IW'(1);
        if (op_r == frt_pkg::ACT_FIND) begin
          if (rd_entry.active && at_or_after_start && before_end) begin
            found_nxt = 1'b1;
            slot_nxt  = 6'(idx_r);
            state_nxt = frt_pkg::ST_FINISH;
          end else if (last_slot) begin
            state_nxt = frt_pkg::ST_FINISH;
          end
        end else begin
          if (rd_entry.active) begin
            ram_we = 1'b1;
            if (at_or_before_start) begin
              ram_wentry.start = rd_entry.start + amt_r;
            end else if (before_end) begin
              ram_wentry.length = rd_entry.length + amt_r;
            end
          end
          if (last_slot) begin
            state_nxt = frt_pkg::ST_FINISH;
          end
        end
      end

      frt_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.found        = found_r;
          out_nxt.slot_out     = slot_r;
          out_nxt.table_full   = full_r;
          out_nxt.active_count = 7'(live_r);
          state_nxt            = frt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = frt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frt_pkg::ST_IDLE;
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    amt_r   <= amt_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    full_r  <= full_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != frt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Every active slot is also a used slot.
  a_live_within_used: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= used_r)
    else $error("active count exceeds used slot count");

  // The fill count never passes the table size.
  a_used_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CAPACITY))
    else $error("used slot count exceeds capacity");

  // A scan only ever looks at used slots.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frt_pkg::ST_SCAN) |-> (CW'(idx_r) < used_r))
    else $error("scan index beyond used slots");

  // A result is only loaded from the finish state, and the controller then returns to idle.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |=> (state_r == frt_pkg::ST_IDLE))
    else $error("result loaded without returning to idle");
`endif

endmodule

`default_nettype wire

FILE: test/tb_fragment_range_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for fragment_range_table: a directed table of items, then random
// traffic under several idle and stall mixes. Depends on frt_pkg and the fragment_range_table RTL.

module tb_fragment_range_table;
  import frt_pkg::*;

  localparam int unsigned SLOTS = FRT_CAPACITY;
  // First of the three action codes that the block ignores.
  localparam logic [2:0] ACT_SPARE = 3'd5;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  // The tail leaves room for the longest walk, over every used slot.
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned MAX_PRINTED = 40;

  // One row of the directed table. When typed is set, want is the result read
  // straight off the behavior; otherwise the shadow table supplies it.
  typedef struct {
    frt_in_t  item;
    bit       typed;
    frt_out_t want;
  } directed_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  frt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  frt_out_t out_data;

  // Shadow copy of the range table, updated as each item is accepted.
  logic [31:0] shadow_start  [SLOTS];
  logic [31:0] shadow_length [SLOTS];
  bit          shadow_active [SLOTS];
  int unsigned slots_used;
  int unsigned live_ranges;
  // Highest slot count ever reached; slots below it hold written data.
  int unsigned written_mark;
  // Adds still to come in a burst that runs the table into its full state.
  int unsigned fill_left;

  frt_out_t    result_fifo [$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // Idle mixes per phase: free flow, sender idle, receiver stalling, both.
  int unsigned idle_plan  [4] = '{0, 54, 0, 10};
  int unsigned stall_plan [4] = '{0, 0, 54, 10};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  fragment_range_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Applies one item to the shadow table and returns the result it must produce.
  // Range bounds are compared as signed 32-bit values; the end wraps before it
  // is compared, so a range whose end wraps negative contains nothing.
  function automatic frt_out_t apply_range_op(input frt_in_t op);
    frt_out_t res;
    longint   point;
    longint   lo;
    longint   hi;
    res   = '0;
    point = longint'(op.position);
    case (op.action)
      ACT_ADD: begin
        if (slots_used >= SLOTS) begin
          res.table_full = 1'b1;
        end else begin
          res.slot_out = 6'(slots_used);
          shadow_start[slots_used]  = {1'b0, op.position};
          shadow_length[slots_used] = op.amount;
          shadow_active[slots_used] = 1'b1;
          slots_used++;
          live_ranges++;
          if (slots_used > written_mark) written_mark = slots_used;
        end
      end
      ACT_REMOVE: begin
        // Unused and already inactive slots leave the table as it is.
        if (op.slot_index < slots_used && shadow_active[op.slot_index]) begin
          shadow_active[op.slot_index] = 1'b0;
          live_ranges--;
        end
      end
      ACT_CLEAR: begin
        foreach (shadow_active[i]) shadow_active[i] = 1'b0;
        slots_used  = 0;
        live_ranges = 0;
      end
      ACT_FIND: begin
        for (int i = 0; i < slots_used; i++) begin
          if (!res.found && shadow_active[i]) begin
            lo = longint'($signed(shadow_start[i]));
            hi = longint'($signed(shadow_start[i] + shadow_length[i]));
            if (point >= lo && point < hi) begin
              res.found    = 1'b1;
              res.slot_out = 6'(i);
            end
          end
        end
      end
      ACT_ADJUST: begin
        // Ranges at or after the edit point move; the one holding it resizes.
        for (int i = 0; i < slots_used; i++) begin
          if (shadow_active[i]) begin
            lo = longint'($signed(shadow_start[i]));
            hi = longint'($signed(shadow_start[i] + shadow_length[i]));
            if (point <= lo) begin
              shadow_start[i] = shadow_start[i] + op.amount;
            end else if (point < hi) begin
              shadow_length[i] = shadow_length[i] + op.amount;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.active_count = 7'(live_ranges);
    return res;
  endfunction

  function automatic directed_row_t make_row(input logic [2:0] act, input logic [30:0] pos,
                                             input logic [31:0] amt, input logic [5:0] idx,
                                             input bit typed, input logic [5:0] slot,
                                             input logic [6:0] count);
    directed_row_t row;
    row.item.action     = act;
    row.item.position   = pos;
    row.item.amount     = amt;
    row.item.slot_index = idx;
    row.typed           = typed;
    row.want            = '0;
    row.want.slot_out     = slot;
    row.want.active_count = count;
    return row;
  endfunction

  // Positions cluster near zero, near the top of the range and in a middle band,
  // so that new ranges overlap and queries land in them.
  function automatic logic [30:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 31'($urandom);
    if (roll < 40) return 31'($urandom_range(400));
    if (roll < 70) return 31'h7FFF_FE00 + 31'($urandom_range(511));
    return 31'(1000 + $urandom_range(600));
  endfunction

  // A position just around the start of a used slot.
  function automatic logic [30:0] near_range(input int unsigned slot);
    return 31'(shadow_start[slot] + 32'($urandom_range(24)) - 32'd3);
  endfunction

  // Draws the next random item from the current shadow state. Removes only
  // name slots that have been written since reset.
  function automatic frt_in_t next_range_op();
    frt_in_t     op;
    int unsigned roll;
    op.action     = ACT_ADD;
    op.position   = pick_position();
    op.amount     = 32'($urandom_range(60, 1));
    op.slot_index = 6'($urandom_range(63));
    if (fill_left > 0) begin
      fill_left--;
      return op;
    end
    roll = $urandom_range(99);
    if (roll < 2) begin
      // Run the table past full, so that the last adds are rejected.
      fill_left = SLOTS + 2 - slots_used;
    end else if (roll < 36) begin
      case ($urandom_range(9))
        0: op.amount = $urandom;
        1: op.amount = 32'($urandom_range(20)) ^ 32'hFFFF_FFFF;
        2: op.amount = '0;
        default: begin
        end
      endcase
    end else if (roll < 60) begin
      op.action = ACT_FIND;
      if (slots_used > 0 && $urandom_range(3) != 0) begin
        op.position = near_range($urandom_range(slots_used - 1));
      end
    end else if (roll < 75) begin
      op.action = ACT_ADJUST;
      op.amount = 32'($urandom_range(40)) - 32'd20;
      if ($urandom_range(9) == 0) op.amount = $urandom;
      if (slots_used > 0 && $urandom_range(1) == 1) begin
        op.position = near_range($urandom_range(slots_used - 1));
      end
    end else if (roll < 92) begin
      if (written_mark == 0) begin
        op.action = ACT_FIND;
      end else begin
        op.action = ACT_REMOVE;
        if (slots_used > 0 && ($urandom_range(5) != 0 || written_mark == slots_used)) begin
          op.slot_index = 6'($urandom_range(slots_used - 1));
        end else begin
          // A slot that was written once but lies beyond the used ones.
          op.slot_index = 6'($urandom_range(written_mark - 1, slots_used));
        end
      end
    end else if (roll < 96) begin
      op.action = ACT_CLEAR;
    end else begin
      op.action = ACT_SPARE + 3'($urandom_range(2));
    end
    return op;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Offers one item, with a random idle gap before it, and records the result
  // it must cause once the block has taken it. Called at a rising edge.
  task automatic send_item(input frt_in_t op, input bit typed, input frt_out_t want);
    frt_out_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    predicted = apply_range_op(op);
    result_fifo = {result_fifo, (typed ? want : predicted)};
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_fifo.size() != 0);
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= rst_n && stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  // Every result taken is checked against the oldest expectation.
  always @(posedge clk) begin
    frt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_fifo.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data), 0);
      end else begin
        want = result_fifo.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.slot_out !== want.slot_out)
          report_mismatch("slot_out", 32'(out_data.slot_out), 32'(want.slot_out));
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", 32'(out_data.table_full), 32'(want.table_full));
        if (out_data.active_count !== want.active_count)
          report_mismatch("active_count", 32'(out_data.active_count),
                          32'(want.active_count));
      end
    end
  end

  initial begin
    directed_row_t rows [$];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    slots_used    = 0;
    live_ranges   = 0;
    written_mark  = 0;
    fill_left     = 0;
    mismatches    = 0;
    foreach (shadow_active[i]) shadow_active[i] = 1'b0;

    // An empty table answers every query with nothing, and spare codes only
    // report the count.
    rows = {rows, make_row(ACT_FIND, 31'd0, 32'd0, 6'd0, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADJUST, 31'd0, 32'd5, 6'd0, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_SPARE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                           1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_SPARE + 3'd1, 31'd77, 32'd1, 6'd21, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_SPARE + 3'd2, 31'd0, 32'h8000_0000, 6'd42,
                           1'b1, 6'd0, 7'd0)};
    // Adds fill slots in order: a plain range, one at the top whose end wraps,
    // a negative length, the most negative length and a second plain range.
    rows = {rows, make_row(ACT_ADD, 31'd0, 32'd10, 6'd0, 1'b1, 6'd0, 7'd1)};
    rows = {rows, make_row(ACT_ADD, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 1'b1, 6'd1, 7'd2)};
    rows = {rows, make_row(ACT_ADD, 31'd100, 32'hFFFF_FFFB, 6'd0, 1'b1, 6'd2, 7'd3)};
    rows = {rows, make_row(ACT_ADD, 31'd40, 32'h8000_0000, 6'd0, 1'b1, 6'd3, 7'd4)};
    rows = {rows, make_row(ACT_ADD, 31'd20, 32'd30, 6'd0, 1'b1, 6'd4, 7'd5)};
    // Hits, misses and edits before, inside and past ranges, with extreme sizes.
    rows = {rows, make_row(ACT_FIND, 31'd5, 32'd0, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_FIND, 31'd25, 32'd0, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_FIND, 31'h7FFF_FFFF, 32'd0, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADJUST, 31'd20, 32'd3, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADJUST, 31'd5, 32'hFFFF_FFF9, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADJUST, 31'd0, 32'h8000_0000, 6'd0, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADJUST, 31'd1, 32'h7FFF_FFFF, 6'd0, 1'b0, 6'd0, 7'd0)};
    // A remove, the same remove of a slot now inactive, and a query after it.
    rows = {rows, make_row(ACT_REMOVE, 31'd0, 32'd0, 6'd4, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_REMOVE, 31'd0, 32'd0, 6'd4, 1'b0, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_FIND, 31'd26, 32'd0, 6'd0, 1'b0, 6'd0, 7'd0)};
    // After clear, a remove of a written but unused slot is ignored and adds
    // start again from slot zero.
    rows = {rows, make_row(ACT_CLEAR, 31'd0, 32'd0, 6'd0, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_REMOVE, 31'd0, 32'd0, 6'd3, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_FIND, 31'd0, 32'd0, 6'd0, 1'b1, 6'd0, 7'd0)};
    rows = {rows, make_row(ACT_ADD, 31'd3, 32'd1, 6'd0, 1'b1, 6'd0, 7'd1)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].want);

    // Random traffic; each phase starts only after the previous one has drained.
    for (int phase = 0; phase < 4; phase++) begin
      wait_for_drain();
      send_idle_pct = idle_plan[phase];
      stall_pct     = stall_plan[phase];
      // The first phase opens by running the table past full.
      if (phase == 0) fill_left = SLOTS + 2 - slots_used;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(next_range_op(), 1'b0, '0);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/frt_pkg.sv
sv/frt_ram.sv
sv/fragment_range_table.sv
test/tb_fragment_range_table.sv
